FILE: hw/rtl/wsfd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsfd_pkg
// Shared types for the WebSocket frame deframer: parse phases and the
// result item that travels from the parser to the output buffer.
// ---------------------------------------------------------------------------
package wsfd_pkg;

    // Header length codes and header field byte counts
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;
    localparam logic [3:0] KEY_BYTES      = 4'd4;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_B0    = 6'b000001,
        PH_B1    = 6'b000010,
        PH_EXT16 = 6'b000100,
        PH_EXT64 = 6'b001000,
        PH_KEY   = 6'b010000,
        PH_DATA  = 6'b100000
    } t_phase;

    // One result item
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [3:0]  opcode;
        logic        fin;
        logic        was_masked;
        logic [63:0] frame_length;
        logic        last_of_frame;
        logic        empty_frame;
    } t_result;

endpackage
`default_nettype wire

FILE: hw/rtl/wsfd_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsfd_parser
// Frame header state machine and payload unmasking. Consumes one byte per
// accepted item and offers at most one result item in the same cycle.
// ---------------------------------------------------------------------------
module wsfd_parser (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [7:0]            i_in_byte,
    output logic                  o_res_valid,
    output wsfd_pkg::t_result     o_res
);

    wsfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_hbc, n_hbc;
    logic [63:0]      r_len, n_len;
    logic [63:0]      r_idx, n_idx;
    logic [31:0]      r_key, n_key;
    logic             r_fin, n_fin;
    logic [3:0]       r_opcode, n_opcode;
    logic             r_masked, n_masked;

    logic [63:0]      idx_inc;
    logic [7:0]       key_byte;
    logic             is_last;

    assign idx_inc = r_idx + 64'd1;
    assign is_last = (idx_inc == r_len);

    // Select key byte by payload index mod 4, first key byte on top
    always_comb begin
        case (r_idx[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    // Next state and result for the byte at the input
    always_comb begin
        n_phase  = r_phase;
        n_hbc    = r_hbc;
        n_len    = r_len;
        n_idx    = r_idx;
        n_key    = r_key;
        n_fin    = r_fin;
        n_opcode = r_opcode;
        n_masked = r_masked;
        o_res_valid          = 1'b0;
        o_res.payload_byte   = 8'd0;
        o_res.last_of_frame  = 1'b1;
        o_res.empty_frame    = 1'b1;

        case (r_phase)
            wsfd_pkg::PH_B0: begin
                n_fin    = i_in_byte[7];
                n_opcode = i_in_byte[3:0];
                n_phase  = wsfd_pkg::PH_B1;
            end
            wsfd_pkg::PH_B1: begin
                n_masked = i_in_byte[7];
                n_key    = 32'd0;
                n_hbc    = 4'd0;
                if (i_in_byte[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
                    n_len   = 64'd0;
                    n_phase = wsfd_pkg::PH_EXT16;
                end else if (i_in_byte[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
                    n_len   = 64'd0;
                    n_phase = wsfd_pkg::PH_EXT64;
                end else begin
                    n_len = {57'd0, i_in_byte[6:0]};
                    if (i_in_byte[7]) begin
                        n_phase = wsfd_pkg::PH_KEY;
                    end else begin
                        n_idx = 64'd0;
                        if (i_in_byte[6:0] == 7'd0) begin
                            o_res_valid = 1'b1;
                            n_phase     = wsfd_pkg::PH_B0;
                        end else begin
                            n_phase = wsfd_pkg::PH_DATA;
                        end
                    end
                end
            end
            wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
                n_len = {r_len[55:0], i_in_byte};
                n_hbc = r_hbc + 4'd1;
                if ((r_phase == wsfd_pkg::PH_EXT16 && n_hbc == wsfd_pkg::EXT16_BYTES) ||
                    (r_phase == wsfd_pkg::PH_EXT64 && n_hbc == wsfd_pkg::EXT64_BYTES)) begin
                    n_hbc = 4'd0;
                    if (r_masked) begin
                        n_phase = wsfd_pkg::PH_KEY;
                    end else begin
                        n_idx = 64'd0;
                        if (n_len == 64'd0) begin
                            o_res_valid = 1'b1;
                            n_phase     = wsfd_pkg::PH_B0;
                        end else begin
                            n_phase = wsfd_pkg::PH_DATA;
                        end
                    end
                end
            end
            wsfd_pkg::PH_KEY: begin
                n_key = {r_key[23:0], i_in_byte};
                n_hbc = r_hbc + 4'd1;
                if (n_hbc == wsfd_pkg::KEY_BYTES) begin
                    n_hbc = 4'd0;
                    n_idx = 64'd0;
                    if (r_len == 64'd0) begin
                        o_res_valid = 1'b1;
                        n_phase     = wsfd_pkg::PH_B0;
                    end else begin
                        n_phase = wsfd_pkg::PH_DATA;
                    end
                end
            end
            wsfd_pkg::PH_DATA: begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = r_masked ? (i_in_byte ^ key_byte) : i_in_byte;
                o_res.last_of_frame = is_last;
                o_res.empty_frame   = 1'b0;
                n_idx               = idx_inc;
                if (is_last) begin
                    n_phase = wsfd_pkg::PH_B0;
                end
            end
            default: begin
                n_phase = wsfd_pkg::PH_B0;
            end
        endcase

        // Tag with the header fields as they stand after this byte
        o_res.opcode       = n_opcode;
        o_res.fin          = n_fin;
        o_res.was_masked   = n_masked;
        o_res.frame_length = n_len;
    end

    // Advance parse state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_B0;
            r_hbc    <= 4'd0;
            r_len    <= 64'd0;
            r_idx    <= 64'd0;
            r_key    <= 32'd0;
            r_fin    <= 1'b0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_hbc    <= n_hbc;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_key    <= n_key;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/wsfd_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsfd_out_buf
// Output register with a skid stage. Takes a result item every cycle and
// stalls the input side only when the skid stage is occupied.
// ---------------------------------------------------------------------------
module wsfd_out_buf (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire  wsfd_pkg::t_result i_res,
    input  wire                   i_stall,
    output logic                  o_full,
    output logic                  o_valid,
    output wsfd_pkg::t_result     o_res
);

    logic              r_out_valid;
    wsfd_pkg::t_result r_out;
    logic              r_skid_valid;
    wsfd_pkg::t_result r_skid;
    logic              take;

    assign take    = r_out_valid & ~i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Control: refill output from skid first, else from the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Data: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer_top.sv
`default_nettype none
// A result item is registered into the output register, or the skid stage if stalled.
// One byte is accepted per cycle while o_stall is low; the parser state updates per byte.
// Header bytes produce no result; each payload byte (or an empty frame) produces one.
// The input stalls only while the skid stage behind the output register is occupied.
// Reset (synchronous, active low) returns the parser to the first header byte
// and empties the output register and skid stage.
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top
// WebSocket receive-side deframer: header parse, payload unmasking, tagging.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire  [7:0]  i_in_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [7:0]  o_payload_byte,
    output logic [3:0]  o_opcode,
    output logic        o_fin,
    output logic        o_was_masked,
    output logic [63:0] o_frame_length,
    output logic        o_last_of_frame,
    output logic        o_empty_frame,
    input  wire         i_stall
);

    logic              accept;
    logic              res_valid;
    logic              buf_full;
    wsfd_pkg::t_result res;
    wsfd_pkg::t_result out_res;

    assign o_stall = buf_full;
    assign accept  = i_valid & ~buf_full;

    // Parse and unmask
    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Register results toward the output
    wsfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept & res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_payload_byte  = out_res.payload_byte;
    assign o_opcode        = out_res.opcode;
    assign o_fin           = out_res.fin;
    assign o_was_masked    = out_res.was_masked;
    assign o_frame_length  = out_res.frame_length;
    assign o_last_of_frame = out_res.last_of_frame;
    assign o_empty_frame   = out_res.empty_frame;

endmodule
`default_nettype wire

FILE: test/websocket_frame_deframer_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// websocket_frame_deframer_top_test
// Streams framed bytes into the deframer: a few directed frames (empty,
// masked, extended lengths), then random frames of every length form, and
// a huge-length frame at the tail. A scoreboard parses the same stream,
// predicts each tagged payload item, and checks the output item by item.
// ---------------------------------------------------------------------------
module websocket_frame_deframer_top_test ();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 1500;
    localparam int IDLE_PCT       = 28;

    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} t_len_form;

    // Parses the byte stream and holds the tagged items still to come out
    class deframer_scoreboard;
        wsfd_pkg::t_result expected_items[$];
        int                errors = 0;
        wsfd_pkg::t_phase  parse_phase = wsfd_pkg::PH_B0;
        logic [3:0]        hdr_count = '0;
        logic [63:0]       frame_len = '0;
        logic [63:0]       data_index = '0;
        logic [31:0]       mask_word = '0;
        logic              frame_fin = 1'b0;
        logic [3:0]        frame_op = '0;
        logic              frame_masked = 1'b0;

        function int pending();
            return expected_items.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void emit_item(logic [7:0] data, logic last, logic empty);
            wsfd_pkg::t_result item;
            item.payload_byte  = data;
            item.opcode        = frame_op;
            item.fin           = frame_fin;
            item.was_masked    = frame_masked;
            item.frame_length  = frame_len;
            item.last_of_frame = last;
            item.empty_frame   = empty;
            expected_items.push_back(item);
        endfunction

        // Header done: a zero length closes the frame at once
        function void begin_payload();
            data_index = '0;
            if (frame_len == 64'd0) begin
                emit_item(8'h00, 1'b1, 1'b1);
                parse_phase = wsfd_pkg::PH_B0;
            end else begin
                parse_phase = wsfd_pkg::PH_DATA;
            end
        endfunction

        function void length_done();
            hdr_count = '0;
            if (frame_masked)
                parse_phase = wsfd_pkg::PH_KEY;
            else
                begin_payload();
        endfunction

        // Advance the parser by one accepted byte
        function void note_byte(logic [7:0] b);
            logic [7:0] key_byte;
            logic       last;
            case (parse_phase)
                wsfd_pkg::PH_B0: begin
                    frame_fin   = b[7];
                    frame_op    = b[3:0];
                    parse_phase = wsfd_pkg::PH_B1;
                end
                wsfd_pkg::PH_B1: begin
                    frame_masked = b[7];
                    mask_word    = '0;
                    hdr_count    = '0;
                    if (b[6:0] == wsfd_pkg::LEN_CODE_EXT16) begin
                        frame_len   = '0;
                        parse_phase = wsfd_pkg::PH_EXT16;
                    end else if (b[6:0] == wsfd_pkg::LEN_CODE_EXT64) begin
                        frame_len   = '0;
                        parse_phase = wsfd_pkg::PH_EXT64;
                    end else begin
                        frame_len = {57'd0, b[6:0]};
                        length_done();
                    end
                end
                wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
                    frame_len = {frame_len[55:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count >= ((parse_phase == wsfd_pkg::PH_EXT16) ?
                                      wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES))
                        length_done();
                end
                wsfd_pkg::PH_KEY: begin
                    mask_word = {mask_word[23:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count >= wsfd_pkg::KEY_BYTES) begin
                        hdr_count = '0;
                        begin_payload();
                    end
                end
                wsfd_pkg::PH_DATA: begin
                    key_byte = frame_masked ? mask_word[8 * (3 - data_index[1:0]) +: 8] : 8'h00;
                    last     = (data_index + 64'd1 == frame_len);
                    emit_item(b ^ key_byte, last, 1'b0);
                    data_index = data_index + 64'd1;
                    if (last)
                        parse_phase = wsfd_pkg::PH_B0;
                end
                default: parse_phase = wsfd_pkg::PH_B0;
            endcase
        endfunction

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(wsfd_pkg::t_result got);
            wsfd_pkg::t_result want;
            if (expected_items.size() == 0) begin
                report("result item with nothing expected");
                return;
            end
            want = expected_items.pop_front();
            compare_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
            compare_field("opcode", 64'(got.opcode), 64'(want.opcode));
            compare_field("fin", 64'(got.fin), 64'(want.fin));
            compare_field("was_masked", 64'(got.was_masked), 64'(want.was_masked));
            compare_field("frame_length", got.frame_length, want.frame_length);
            compare_field("last_of_frame", 64'(got.last_of_frame), 64'(want.last_of_frame));
            compare_field("empty_frame", 64'(got.empty_frame), 64'(want.empty_frame));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_in_byte;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_payload_byte;
    logic [3:0]  o_opcode;
    logic        o_fin;
    logic        o_was_masked;
    logic [63:0] o_frame_length;
    logic        o_last_of_frame;
    logic        o_empty_frame;

    deframer_scoreboard sb;
    int  n_bytes = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;

    websocket_frame_deframer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_in_byte       (i_in_byte),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .o_payload_byte  (o_payload_byte),
        .o_opcode        (o_opcode),
        .o_fin           (o_fin),
        .o_was_masked    (o_was_masked),
        .o_frame_length  (o_frame_length),
        .o_last_of_frame (o_last_of_frame),
        .o_empty_frame   (o_empty_frame),
        .i_stall         (i_stall)
    );

    always #1 i_clk = ~i_clk;

    // Stall the output side at random, except in the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_payload_byte, o_opcode, o_fin, o_was_masked,
                             o_frame_length, o_last_of_frame, o_empty_frame});
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one byte, hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        no_idle = (n_bytes >= 500 && n_bytes < 800);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_byte(b);
        n_bytes++;
    endtask

    // Send header, extended length, key and n_data payload bytes
    task automatic send_frame(input logic [7:0] head, input logic masked,
                              input t_len_form form, input logic [63:0] len,
                              input int n_data, input logic [31:0] key,
                              input bit use_fill, input logic [7:0] fill);
        logic [6:0] code;
        case (form)
            LEN_SHORT: code = len[6:0];
            LEN_EXT16: code = wsfd_pkg::LEN_CODE_EXT16;
            default:   code = wsfd_pkg::LEN_CODE_EXT64;
        endcase
        send_byte(head);
        send_byte({masked, code});
        if (form == LEN_EXT16)
            for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
        if (form == LEN_EXT64)
            for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
        if (masked)
            for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
        for (int i = 0; i < n_data; i++)
            send_byte(use_fill ? fill : 8'($urandom));
    endtask

    // Pick a random well-formed frame, mostly short, sometimes extended
    task automatic random_frame();
        int          r;
        t_len_form   form;
        logic [63:0] len;
        r = $urandom_range(99);
        if (r < 8) begin
            len  = '0;
            form = t_len_form'($urandom_range(2));
        end else if (r < 70) begin
            len  = 64'($urandom_range(12, 1));
            form = LEN_SHORT;
        end else if (r < 72) begin
            len  = 64'($urandom_range(125, 100));
            form = LEN_SHORT;
        end else if (r < 86) begin
            len  = ($urandom_range(9) == 0) ? 64'($urandom_range(300, 200))
                                            : 64'($urandom_range(40));
            form = LEN_EXT16;
        end else begin
            len  = 64'($urandom_range(24));
            form = LEN_EXT64;
        end
        send_frame(8'($urandom), 1'($urandom), form, len, int'(len), $urandom, 1'b0, 8'h00);
    endtask

    initial begin
        logic [63:0] huge_len;
        sb = new();
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty frame, masked single byte, masked empty, ext16 forms
        send_frame(8'hFF, 1'b0, LEN_SHORT, 64'd0, 0, 32'h0, 1'b0, 8'h00);
        send_frame(8'h00, 1'b1, LEN_SHORT, 64'd1, 1, 32'hFF00AA55, 1'b1, 8'h00);
        send_frame(8'h8A, 1'b1, LEN_SHORT, 64'd0, 0, 32'h00FF55AA, 1'b0, 8'h00);
        send_frame(8'h81, 1'b0, LEN_EXT16, 64'd2, 2, 32'h0, 1'b1, 8'hFF);
        send_frame(8'h02, 1'b0, LEN_EXT16, 64'd0, 0, 32'h0, 1'b0, 8'h00);

        // Random frames
        while (n_bytes < RANDOM_BYTES + 25)
            random_frame();

        // Huge length with the top bit set: a few payload bytes, never finishes
        huge_len = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        send_frame(8'h82, 1'b1, LEN_EXT64, huge_len, 12, $urandom, 1'b0, 8'h00);
        i_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/wsfd_out_buf.sv
hw/rtl/websocket_frame_deframer_top.sv
test/websocket_frame_deframer_top_test.sv
